@@ rtl/core/first_fit_heap_allocator_unit_defines.svh @@
// Assertion macros for the first-fit heap allocator.
// Used by the top level only; clk and rst_n are taken from the enclosing scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_SAME(lbl, ante, cons)
`define FFHA_ASSERT_NEXT(lbl, ante, cons)
`define FFHA_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ rtl/core/ffha_pkg.sv @@
// Shared types and codes of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam int unsigned OP_W   = 1;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned ARENA_MIN = 64;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NULL = 2'd2;

  localparam logic CFG_ADDR_ARENA = 1'b0;

  // per-field write enables of a header write
  typedef struct packed {
    logic len;
    logic free;
    logic prev;
    logic next;
  } ffha_wmask_t;

endpackage

@@ rtl/core/ffha_hdr_mem.sv @@
// Block header store: length, free mark, prev and next link per granule index.
// Depends on ffha_pkg for the write mask type.
module ffha_hdr_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned LEN_W = 17,
  parameter int unsigned IDX_W = 14
) (
  input  logic                     clk,
  input  ffha_pkg::ffha_wmask_t    wr_mask,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [LEN_W-1:0]         wr_len,
  input  logic                     wr_free,
  input  logic [IDX_W-1:0]         wr_prev,
  input  logic [IDX_W-1:0]         wr_next,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [LEN_W-1:0]         rd_len,
  output logic                     rd_free,
  output logic [IDX_W-1:0]         rd_prev,
  output logic [IDX_W-1:0]         rd_next
);

  logic [LEN_W-1:0] len_mem  [DEPTH];
  logic             free_mem [DEPTH];
  logic [IDX_W-1:0] prev_mem [DEPTH];
  logic [IDX_W-1:0] next_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_mask.len)  len_mem[wr_addr]  <= wr_len;
    if (wr_mask.free) free_mem[wr_addr] <= wr_free;
    if (wr_mask.prev) prev_mem[wr_addr] <= wr_prev;
    if (wr_mask.next) next_mem[wr_addr] <= wr_next;
  end

  always_ff @(posedge clk) begin
    rd_len  <= len_mem[rd_addr];
    rd_free <= free_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
  end

endmodule

@@ rtl/core/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator: sequencer, APB register, result port.
// Depends on ffha_pkg, ffha_hdr_mem and first_fit_heap_allocator_unit_defines.svh.
//
//  channel | ports                                        | transfer
//  --------+----------------------------------------------+--------------------------
//  input   | start, busy, in_operation/request_size/...   | start high, busy low
//  result  | out_valid, out_grant_offset, out_status      | out_valid high, one cycle
//  config  | psel penable pwrite paddr pwdata prdata      | psel&penable&pwrite&pready
//
// Each header read goes through one port: address first, then registered data.
// Allocate: a header read and check per block walked, then up to 3 header writes, plus a
// second walk for the next free block when the lowest free block is granted whole.
// Free: a header read and check per block walked from the root, then merging with free neighbours.
// After reset or an arena write, S_INIT rebuilds the root header (busy high).
// Results come in the cycle after the last step and cannot be stalled.
`include "first_fit_heap_allocator_unit_defines.svh"
module first_fit_heap_allocator_unit #(
  parameter int unsigned ARENA_MAX_BYTES = 65536,
  parameter int unsigned HEADER_BYTES    = 40,
  parameter int unsigned GRANULE_BYTES   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ffha_pkg::OP_W-1:0]      in_operation,
  input  logic [ffha_pkg::REQ_W-1:0]     in_request_size,
  input  logic [ffha_pkg::OFF_W-1:0]     in_block_offset,
  output logic                           out_valid,
  output logic [ffha_pkg::OFF_W-1:0]     out_grant_offset,
  output logic [ffha_pkg::STAT_W-1:0]    out_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned HDR_SPAN =
    ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam int unsigned DEPTH = ARENA_MAX_BYTES / GRANULE_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IDX_W = AW + 1;
  localparam int unsigned GSH   = $clog2(GRANULE_BYTES);
  localparam int unsigned LEN_W = $clog2(ARENA_MAX_BYTES) + 1;
  localparam int unsigned W     = (LEN_W > 17) ? LEN_W : 17;
  localparam int unsigned ARENA_RST =
    ((65536 > ARENA_MAX_BYTES ? ARENA_MAX_BYTES : 65536) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam logic [W-1:0]     GMASK = W'(GRANULE_BYTES - 1);
  localparam logic [W-1:0]     HDR_W = W'(HDR_SPAN);
  localparam logic [IDX_W-1:0] NIL   = IDX_W'(DEPTH);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] A_RD      = 5'd2;
  localparam logic [4:0] A_CHK     = 5'd3;
  localparam logic [4:0] A_W1      = 5'd4;
  localparam logic [4:0] A_W2      = 5'd5;
  localparam logic [4:0] A_W3      = 5'd6;
  localparam logic [4:0] A_WF      = 5'd7;
  localparam logic [4:0] A_NF_RD   = 5'd8;
  localparam logic [4:0] A_NF_CHK  = 5'd9;
  localparam logic [4:0] F_RD      = 5'd10;
  localparam logic [4:0] F_CHK     = 5'd11;
  localparam logic [4:0] F_NX_RD   = 5'd12;
  localparam logic [4:0] F_NX_CHK  = 5'd13;
  localparam logic [4:0] F_WB      = 5'd14;
  localparam logic [4:0] F_WNP     = 5'd15;
  localparam logic [4:0] F_PV_RD   = 5'd16;
  localparam logic [4:0] F_PV_CHK  = 5'd17;
  localparam logic [4:0] F_WP      = 5'd18;
  localparam logic [4:0] F_WPP     = 5'd19;
  localparam logic [4:0] F_FIN     = 5'd20;
  localparam logic [4:0] S_OUT     = 5'd21;

  logic [4:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            b_r, b_nxt;
  logic [IDX_W-1:0]            nx_r, nx_nxt;
  logic [IDX_W-1:0]            pv_r, pv_nxt;
  logic [IDX_W-1:0]            rb_r, rb_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [IDX_W-1:0]            ff_r, ff_nxt;
  logic [W-1:0]                len_r, len_nxt;
  logic [W-1:0]                size_r, size_nxt;
  logic [W-1:0]                arena_r, arena_nxt;
  logic [ffha_pkg::OFF_W-1:0]  grant_r, grant_nxt;
  logic [ffha_pkg::STAT_W-1:0] status_r, status_nxt;

  ffha_pkg::ffha_wmask_t wr_mask;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [LEN_W-1:0]      wr_len, rd_len;
  logic                  wr_free, rd_free;
  logic [IDX_W-1:0]      wr_prev, wr_next, rd_prev, rd_next;

  logic                  cfg_we;
  logic [W-1:0]          cfg_v;
  logic [W-1:0]          rd_len_w, rem, rsum;
  logic [31:0]           grant_full;
  logic [ffha_pkg::OFF_W-1:0] offd;
  logic [31:0]           idx_full;

  assign pready = 1'b1;
  assign prdata = 32'(arena_r);
  assign cfg_we = psel && penable && pwrite && pready && (paddr == ffha_pkg::CFG_ADDR_ARENA);

  always_comb begin
    cfg_v = W'(pwdata[ffha_pkg::CFG_W-1:0]);
    if (cfg_v < W'(ffha_pkg::ARENA_MIN)) cfg_v = W'(ffha_pkg::ARENA_MIN);
    if (cfg_v > W'(ARENA_MAX_BYTES))     cfg_v = W'(ARENA_MAX_BYTES);
    cfg_v = cfg_v & ~GMASK;
  end

  // an arena write takes the idle cycle, so no item is taken beside it
  assign busy      = (state_r != S_IDLE) || cfg_we;
  assign out_valid = (state_r == S_OUT);
  assign out_grant_offset = grant_r;
  assign out_status       = status_r;

  assign rd_len_w   = W'(rd_len);
  assign rem        = rd_len_w - size_r;
  // index of the split-off remainder header
  assign rsum       = W'(b_r) + ((HDR_W + size_r) >> GSH);
  assign grant_full = (32'(b_r) << GSH) + 32'(HDR_SPAN);
  assign offd       = in_block_offset - ffha_pkg::OFF_W'(HDR_SPAN);
  assign idx_full   = 32'(offd) >> GSH;

  ffha_hdr_mem #(
    .DEPTH(DEPTH), .LEN_W(LEN_W), .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk), .wr_mask(wr_mask), .wr_addr(wr_addr), .wr_len(wr_len),
    .wr_free(wr_free), .wr_prev(wr_prev), .wr_next(wr_next), .rd_addr(rd_addr),
    .rd_len(rd_len), .rd_free(rd_free), .rd_prev(rd_prev), .rd_next(rd_next)
  );

  always_comb begin
    state_nxt  = state_r;
    b_nxt      = b_r;
    nx_nxt     = nx_r;
    pv_nxt     = pv_r;
    rb_nxt     = rb_r;
    idx_nxt    = idx_r;
    ff_nxt     = ff_r;
    len_nxt    = len_r;
    size_nxt   = size_r;
    arena_nxt  = arena_r;
    grant_nxt  = grant_r;
    status_nxt = status_r;
    wr_mask    = '0;
    wr_addr    = b_r[AW-1:0];
    wr_len     = LEN_W'(len_r);
    wr_free    = 1'b1;
    wr_prev    = pv_r;
    wr_next    = nx_r;
    rd_addr    = b_r[AW-1:0];

    case (state_r)
      S_INIT: begin
        wr_mask = '{len: 1'b1, free: 1'b1, prev: 1'b1, next: 1'b1};
        wr_addr = '0;
        wr_len  = (arena_r > HDR_W) ? LEN_W'(arena_r - HDR_W) : '0;
        wr_prev = NIL;
        wr_next = NIL;
        ff_nxt  = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        grant_nxt  = '0;
        status_nxt = ffha_pkg::ST_OK;
        if (cfg_we) begin
          arena_nxt = cfg_v;
          state_nxt = S_INIT;
        end else if (start) begin
          if (in_operation == ffha_pkg::OP_ALLOC) begin
            size_nxt = ((W'(in_request_size) + GMASK) >> GSH) << GSH;
            b_nxt    = ff_r;
            if (ff_r >= NIL) begin
              status_nxt = ffha_pkg::ST_OOM;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = A_RD;
            end
          end else if (in_block_offset == '0) begin
            status_nxt = ffha_pkg::ST_NULL;
            state_nxt  = S_OUT;
          end else if (in_block_offset < ffha_pkg::OFF_W'(HDR_SPAN) ||
                       (offd & ffha_pkg::OFF_W'(GRANULE_BYTES - 1)) != '0 ||
                       idx_full >= 32'(DEPTH)) begin
            state_nxt = S_OUT;
          end else begin
            idx_nxt   = IDX_W'(idx_full);
            b_nxt     = '0;
            state_nxt = F_RD;
          end
        end
      end
      A_RD: state_nxt = A_CHK;
      A_CHK: begin
        if (rd_free && rd_len_w >= size_r) begin
          len_nxt   = rd_len_w;
          nx_nxt    = rd_next;
          grant_nxt = grant_full[ffha_pkg::OFF_W-1:0];
          if (rem >= HDR_W) begin
            rb_nxt    = IDX_W'(rsum);
            state_nxt = (rsum < W'(DEPTH)) ? A_W1 : S_OUT;
          end else begin
            state_nxt = A_WF;
          end
        end else if (rd_next >= NIL) begin
          status_nxt = ffha_pkg::ST_OOM;
          state_nxt  = S_OUT;
        end else begin
          b_nxt     = rd_next;
          state_nxt = A_RD;
        end
      end
      A_W1: begin
        wr_mask = '{len: 1'b1, free: 1'b1, prev: 1'b1, next: 1'b1};
        wr_addr = rb_r[AW-1:0];
        wr_len  = LEN_W'(len_r - size_r - HDR_W);
        wr_prev = b_r;
        wr_next = nx_r;
        state_nxt = A_W2;
      end
      A_W2: begin
        wr_mask.prev = (nx_r < NIL);
        wr_addr = nx_r[AW-1:0];
        wr_prev = rb_r;
        state_nxt = A_W3;
      end
      A_W3: begin
        wr_mask = '{len: 1'b1, free: 1'b1, prev: 1'b0, next: 1'b1};
        wr_len  = LEN_W'(size_r);
        wr_free = 1'b0;
        wr_next = rb_r;
        if (ff_r == b_r) ff_nxt = rb_r;
        state_nxt = S_OUT;
      end
      A_WF: begin
        wr_mask.free = 1'b1;
        wr_free = 1'b0;
        state_nxt = S_OUT;
        if (ff_r == b_r) begin
          if (nx_r < NIL) begin
            b_nxt     = nx_r;
            state_nxt = A_NF_RD;
          end else begin
            ff_nxt = NIL;
          end
        end
      end
      A_NF_RD: state_nxt = A_NF_CHK;
      A_NF_CHK: begin
        if (rd_free) begin
          ff_nxt    = b_r;
          state_nxt = S_OUT;
        end else if (rd_next < NIL) begin
          b_nxt     = rd_next;
          state_nxt = A_NF_RD;
        end else begin
          ff_nxt    = NIL;
          state_nxt = S_OUT;
        end
      end
      F_RD: state_nxt = F_CHK;
      F_CHK: begin
        if (b_r == idx_r) begin
          if (rd_free) begin
            state_nxt = S_OUT;
          end else begin
            len_nxt   = rd_len_w;
            nx_nxt    = rd_next;
            pv_nxt    = rd_prev;
            state_nxt = (rd_next < NIL) ? F_NX_RD : F_WB;
          end
        end else if (rd_next < NIL) begin
          b_nxt     = rd_next;
          state_nxt = F_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      F_NX_RD: begin
        rd_addr   = nx_r[AW-1:0];
        state_nxt = F_NX_CHK;
      end
      F_NX_CHK: begin
        if (rd_free) begin
          len_nxt = len_r + HDR_W + rd_len_w;
          nx_nxt  = rd_next;
        end
        state_nxt = F_WB;
      end
      F_WB: begin
        wr_mask = '{len: 1'b1, free: 1'b1, prev: 1'b0, next: 1'b1};
        state_nxt = F_WNP;
      end
      F_WNP: begin
        // prev link of the following block points back here (a no-op without merge)
        wr_mask.prev = (nx_r < NIL);
        wr_addr = nx_r[AW-1:0];
        wr_prev = b_r;
        state_nxt = (pv_r < NIL) ? F_PV_RD : F_FIN;
      end
      F_PV_RD: begin
        rd_addr   = pv_r[AW-1:0];
        state_nxt = F_PV_CHK;
      end
      F_PV_CHK: begin
        if (rd_free) begin
          len_nxt   = rd_len_w + HDR_W + len_r;
          b_nxt     = pv_r;
          state_nxt = F_WP;
        end else begin
          state_nxt = F_FIN;
        end
      end
      F_WP: begin
        wr_mask = '{len: 1'b1, free: 1'b1, prev: 1'b0, next: 1'b1};
        state_nxt = F_WPP;
      end
      F_WPP: begin
        wr_mask.prev = (nx_r < NIL);
        wr_addr = nx_r[AW-1:0];
        wr_prev = b_r;
        state_nxt = F_FIN;
      end
      F_FIN: begin
        if (b_r < ff_r) ff_nxt = b_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (cfg_we) begin
          arena_nxt = cfg_v;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      arena_r  <= W'(ARENA_RST);
      ff_r     <= '0;
      grant_r  <= '0;
      status_r <= ffha_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      arena_r  <= arena_nxt;
      ff_r     <= ff_nxt;
      grant_r  <= grant_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    nx_r   <= nx_nxt;
    pv_r   <= pv_nxt;
    rb_r   <= rb_nxt;
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    size_r <= size_nxt;
  end

  `FFHA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `FFHA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `FFHA_ASSERT_SAME(a_fail_no_grant, out_valid && out_status != ffha_pkg::ST_OK, out_grant_offset == '0)
  `FFHA_ASSERT_NEVER(a_ff_range, ff_r > NIL)

endmodule
